/* sv/nta_pkg.sv */
// Shared types, constants and helpers for the number to ASCII formatter.
`default_nettype none
package nta_pkg;

   // Field widths
   localparam int VALUE_W     = 32;
   localparam int CMD_W       = 2;
   localparam int HEX_WIDTH_W = 4;
   localparam int CHAR_W      = 7;
   localparam int NIB_W       = 4;

   // Decimal digit limit default and fixed hex digit count
   localparam int MAX_DEC_DIGITS_DEF = 8;
   localparam int HEX_DIGITS         = 8;

   // Format commands
   localparam logic [CMD_W-1:0] CMD_DEC    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_HEX_LO = 2'd1;
   localparam logic [CMD_W-1:0] CMD_HEX_UP = 2'd2;

   // ASCII anchors
   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
   localparam logic [NIB_W-1:0]  NIB_MASK      = 4'h0F;

   typedef struct packed {
      logic [CMD_W-1:0]       cmd;
      logic [VALUE_W-1:0]     value;
      logic [HEX_WIDTH_W-1:0] hex_width;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last;
      logic              error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT,
      ST_ERR
   } state_type;

   // 10^digits, evaluated at elaboration
   function automatic longint dec_limit(input int digits);
      longint acc;
      acc = 1;
      for (int i = 0; i < digits; i++) begin
         acc = acc * 10;
      end
      return acc;
   endfunction

   // One nibble to its ASCII digit or letter
   function automatic logic [CHAR_W-1:0] nib_to_ascii(input logic [NIB_W-1:0] nib,
                                                      input logic upper);
      logic [NIB_W-1:0] n;
      n = nib & NIB_MASK;
      if (n < 4'd10) begin
         return ASCII_ZERO + CHAR_W'(n);
      end
      return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'(n) - CHAR_W'(10);
   endfunction

endpackage
`default_nettype wire

/* sv/nta_bcd.sv */
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`default_nettype none
module nta_bcd import nta_pkg::*; #(
   parameter int DIGITS   = MAX_DEC_DIGITS_DEF,
   parameter int BIN_BITS = 27
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [BIN_BITS-1:0]   bin,
   output logic                       done,
   output logic [4*DIGITS-1:0]        bcd
);

   localparam int BCD_W = 4 * DIGITS;
   localparam int CNT_W = $clog2(BIN_BITS + 1);

   logic [BIN_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in;
   logic [BCD_W-1:0]    adj;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                    : bcd_ff[4*i +: 4];
      end
   end

   // Shift control
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = bin;
         bcd_in  = '0;
         cnt_in  = CNT_W'(BIN_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[BIN_BITS-1]};
         bin_in = bin_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
`default_nettype wire

/* sv/nta_out.sv */
// Result output register: holds one beat toward the receiver.
`default_nettype none
module nta_out import nta_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         ready,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Slot is free when empty or its beat leaves this cycle
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (push) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule
`default_nettype wire

/* sv/number_to_ascii_formatter_core.sv */
// Top level of the number to ASCII formatter: sequencer and nibble shifter.
//
// Usage: one number enters on the req channel (req_valid/req_stall, payload
// cmd, value, hex_width) and leaves as a stream of ASCII characters on the
// rsp channel, most significant first, one beat per character, last set on
// the final one. A decimal value of 10^MAX_DEC_DIGITS or more gives a single
// beat with error set and ascii_char 0.
// One number is handled at a time; req_stall stays high until its final beat
// has been written into the output register, so the next number is taken
// while that beat still waits for the receiver.
// Hex: a left-aligned nibble shifter drops the unused upper nibbles one per
// cycle, then gives one character per cycle while the output register is
// ready.
// Decimal: the bit-serial BCD converter takes one bit per cycle, then the
// same nibble shifter skips leading zeros.
// Reset clears the sequencer and empties the output register.
// A stalled receiver holds the current beat; the sequencer waits and loses
// nothing.
`default_nettype none
module number_to_ascii_formatter_core import nta_pkg::*; #(
   parameter int MAX_DEC_DIGITS = MAX_DEC_DIGITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp
);

   localparam longint DEC_LIMIT = dec_limit(MAX_DEC_DIGITS);
   localparam int     DEC_BITS  = $clog2(DEC_LIMIT);
   localparam int     BCD_W     = 4 * MAX_DEC_DIGITS;
   localparam int     SH_DIGS   = (MAX_DEC_DIGITS > HEX_DIGITS) ? MAX_DEC_DIGITS
                                                                : HEX_DIGITS;
   localparam int     SH_W      = 4 * SH_DIGS;
   localparam int     CNT_W     = $clog2(SH_DIGS + 1);
   localparam logic [VALUE_W:0] LIMIT_V = (VALUE_W + 1)'(DEC_LIMIT);

   state_type              state_ff, state_in;
   logic [SH_W-1:0]        sh_ff, sh_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [HEX_WIDTH_W-1:0] width_ff, width_in;
   logic                   dec_ff, dec_in;
   logic                   upper_ff, upper_in;

   logic             bcd_start;
   logic             bcd_done;
   logic [BCD_W-1:0] bcd;
   logic             out_ready;
   logic             push;
   rsp_type          push_data;
   logic [NIB_W-1:0] top_nib;
   logic             skip;

   assign top_nib   = sh_ff[SH_W-1 -: NIB_W];
   assign req_stall = (state_ff != ST_IDLE);

   // Drop leading nibbles: zeros in decimal, unused positions in hex
   assign skip = dec_ff ? ((top_nib == '0) && (cnt_ff > CNT_W'(1)))
                        : (cnt_ff > CNT_W'(width_ff));

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      sh_in     = sh_ff;
      cnt_in    = cnt_ff;
      width_in  = width_ff;
      dec_in    = dec_ff;
      upper_in  = upper_ff;
      bcd_start = 1'b0;
      push      = 1'b0;
      push_data = '{ascii_char: nib_to_ascii(top_nib, upper_ff),
                    last: (cnt_ff == CNT_W'(1)), error: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               upper_in = req.cmd[1];
               if (req.cmd == CMD_DEC) begin
                  if ({1'b0, req.value} >= LIMIT_V) begin
                     state_in = ST_ERR;
                  end else begin
                     bcd_start = 1'b1;
                     state_in  = ST_CONV;
                  end
               end else begin
                  sh_in    = SH_W'(req.value) << (SH_W - VALUE_W);
                  cnt_in   = CNT_W'(HEX_DIGITS);
                  dec_in   = 1'b0;
                  width_in = ((req.hex_width == '0) ||
                              (req.hex_width > HEX_WIDTH_W'(HEX_DIGITS)))
                             ? HEX_WIDTH_W'(HEX_DIGITS) : req.hex_width;
                  state_in = ST_SKIP;
               end
            end
         end
         ST_CONV: begin
            if (bcd_done) begin
               sh_in    = SH_W'(bcd);
               cnt_in   = CNT_W'(SH_DIGS);
               dec_in   = 1'b1;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (skip) begin
               sh_in  = sh_ff << NIB_W;
               cnt_in = cnt_ff - CNT_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               push   = 1'b1;
               sh_in  = sh_ff << NIB_W;
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            push_data = '{ascii_char: '0, last: 1'b1, error: 1'b1};
            if (out_ready) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sh_ff    <= sh_in;
      cnt_ff   <= cnt_in;
      width_ff <= width_in;
      dec_ff   <= dec_in;
      upper_ff <= upper_in;
   end

   // Bit-serial decimal conversion
   nta_bcd #(
      .DIGITS   (MAX_DEC_DIGITS),
      .BIN_BITS (DEC_BITS)
   ) u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (req.value[DEC_BITS-1:0]),
      .done  (bcd_done),
      .bcd   (bcd)
   );

   // Output register
   nta_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule
`default_nettype wire

/* dv/number_to_ascii_formatter_core_test.sv */
// Self-checking testbench for the number to ASCII formatter core.
`timescale 1ns / 1ps
module number_to_ascii_formatter_core_test;
   import nta_pkg::*;

   // Spare command code: behaves as upper-case hex
   localparam logic [CMD_W-1:0] CMD_HEX_SPARE = 2'd3;
   localparam longint DEC_LIMIT = longint'(10) ** MAX_DEC_DIGITS_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 90;

   // Expected character stream and comparison against the rsp channel
   class char_scoreboard;
      rsp_type pending_chars[$];
      int      mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Work out the characters one accepted number gives
      function void note_number(req_type r);
         logic [VALUE_W-1:0] rest;
         logic [NIB_W-1:0]   nib;
         int                 digs[12];
         int                 n;
         int                 i;
         if (r.cmd == CMD_DEC) begin
            if (longint'(r.value) >= DEC_LIMIT) begin
               pending_chars.push_back(rsp_type'{ascii_char: '0, last: 1'b1, error: 1'b1});
            end else begin
               rest = r.value;
               n = 0;
               // least significant digit first, emitted in reverse
               do begin
                  digs[n] = int'(rest % 10);
                  rest = rest / 10;
                  n++;
               end while (rest != 0);
               for (i = n - 1; i >= 0; i--) begin
                  pending_chars.push_back(rsp_type'{
                     ascii_char: ASCII_ZERO + CHAR_W'(digs[i]),
                     last: (i == 0), error: 1'b0});
               end
            end
         end else begin
            n = (r.hex_width == 0 || r.hex_width > HEX_DIGITS) ? HEX_DIGITS
                                                                : int'(r.hex_width);
            for (i = n - 1; i >= 0; i--) begin
               nib = r.value[4*i +: 4];
               pending_chars.push_back(rsp_type'{
                  ascii_char: (nib < 10) ? ASCII_ZERO + CHAR_W'(nib)
                            : (r.cmd[1] ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'(nib - 10),
                  last: (i == 0), error: 1'b0});
            end
         end
      endfunction

      // Compare one accepted beat with the oldest expectation
      function void check_char(rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: char %h last %b error %b",
                        got.ascii_char, got.last, got.error);
            return;
         end
         want = pending_chars.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected char %h last %b error %b, got char %h last %b error %b",
                        want.ascii_char, want.last, want.error,
                        got.ascii_char, got.last, got.error);
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req       = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   int  send_pct   = 0;
   int  stall_pct  = 0;
   logic hold_tag  = 1'b0;
   logic seen_tag  = 1'b0;
   int  hold_left  = 0;
   int  cycle_count = 0;

   char_scoreboard sb = new();

   number_to_ascii_formatter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: random stall, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_tag != seen_tag) begin
         seen_tag = hold_tag;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watch both channels; a beat moves when valid is high and stall low
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_char(rsp);
         if (req_valid && !req_stall) sb.note_number(req);
      end
   end

   function automatic req_type pack_number(logic [CMD_W-1:0] c, logic [VALUE_W-1:0] v,
                                           logic [HEX_WIDTH_W-1:0] w);
      req_type r;
      r.cmd = c;
      r.value = v;
      r.hex_width = w;
      return r;
   endfunction

   // Mostly in-range decimals of every length, plus small and full-range values
   function automatic req_type random_number();
      req_type r;
      int      digits;
      int      lo;
      int      hi;
      r.cmd = CMD_W'($urandom_range(3));
      r.hex_width = HEX_WIDTH_W'($urandom_range(15));
      case ($urandom_range(9))
         0, 1, 2: r.value = $urandom;
         3:       r.value = $urandom_range(15);
         default: begin
            digits = $urandom_range(MAX_DEC_DIGITS_DEF, 1);
            lo = (digits == 1) ? 0 : 10 ** (digits - 1);
            hi = 10 ** digits - 1;
            r.value = $urandom_range(hi, lo);
         end
      endcase
      return r;
   endfunction

   // Offer one number after a random gap and wait until it is taken
   task automatic push_number(input req_type item);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input int count);
      send_pct = s_pct;
      stall_pct <= r_pct;
      repeat (count) push_number(random_number());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: digit-count edges, too-long decimal, widths, cases
      push_number(pack_number(CMD_DEC, 32'd0, 4'd0));
      push_number(pack_number(CMD_DEC, 32'd1, 4'd15));
      push_number(pack_number(CMD_DEC, 32'd9, 4'd3));
      push_number(pack_number(CMD_DEC, 32'd10, 4'd0));
      push_number(pack_number(CMD_DEC, 32'd12345678, 4'd8));
      push_number(pack_number(CMD_DEC, 32'd99999999, 4'd0));
      push_number(pack_number(CMD_DEC, 32'd100000000, 4'd0));
      push_number(pack_number(CMD_DEC, 32'hFFFF_FFFF, 4'd15));
      push_number(pack_number(CMD_HEX_LO, 32'hDEAD_BEEF, 4'd0));
      push_number(pack_number(CMD_HEX_LO, 32'hDEAD_BEEF, 4'd8));
      push_number(pack_number(CMD_HEX_LO, 32'hDEAD_BEEF, 4'd1));
      push_number(pack_number(CMD_HEX_LO, 32'h0123_4567, 4'd9));
      push_number(pack_number(CMD_HEX_LO, 32'h89AB_CDEF, 4'd15));
      push_number(pack_number(CMD_HEX_LO, 32'h0000_0000, 4'd3));
      push_number(pack_number(CMD_HEX_UP, 32'hABCD_EF01, 4'd4));
      push_number(pack_number(CMD_HEX_UP, 32'hFFFF_FFFF, 4'd8));
      push_number(pack_number(CMD_HEX_UP, 32'h0000_0000, 4'd0));
      push_number(pack_number(CMD_HEX_SPARE, 32'hFEDC_BA98, 4'd0));
      push_number(pack_number(CMD_HEX_SPARE, 32'h5A5A_A5A5, 4'd7));

      // Receiver holds off while the sender keeps offering numbers
      send_pct = 0;
      stall_pct <= 0;
      hold_tag <= ~hold_tag;
      repeat (20) push_number(random_number());

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(75, 0, PHASE_ITEMS);
      run_phase(0, 75, PHASE_ITEMS);
      run_phase(23, 23, PHASE_ITEMS);

      req_valid <= 1'b0;
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (sb.pending_chars.size() != 0)
         $display("%0d expected beats never arrived", sb.pending_chars.size());
      if (sb.mismatches == 0 && sb.pending_chars.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
